[src/touch_sample_average_calibrate_macros.svh]
// Assertion macros used by the checker of the touch averager.
`ifndef TOUCH_SAMPLE_AVERAGE_CALIBRATE_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGE_CALIBRATE_MACROS_SVH

// Check that a condition holds in the cycle after an antecedent, outside of reset.
`define TSAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check a condition in the cycle after reset is applied.
`define TSAC_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

[src/tsac_pkg.sv]
package tsac_pkg;

  // Payload widths on the stream ports
  localparam int DATA_W     = 8;
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Default sample limit per batch
  localparam int MAX_SAMPLES_DEF = 128;

endpackage

[src/touch_sample_average_calibrate.sv]
// Touch sample averager with linear calibration.
//
// Slave stream s_*: one FIFO byte per beat in s_tdata, s_tlast marks the
// last byte of a batch. Bytes pack into samples of three bytes (x, y) or four
// bytes (x, y, pressure) as selected by the xyz_mode register. Each complete
// sample is summed per axis in the cycle its last byte is taken.
// Master stream m_*: one result beat per batch. The register port cfg_* takes
// xyz_mode, bias_x, ratio_x, bias_y, ratio_y by index; it is always ready
// and must only be written while the block is idle.
//
// Plain bytes are taken back to back while the block is idle. The byte flagged
// last starts a sequence on one shared restoring divider: three averaging
// divisions and two calibration divisions, each a load, restoring steps and a
// store, before the result is written to the output register; s_tready is low meanwhile.
// The result sits in an output register: bytes of the next batch keep flowing
// while it waits. If m_tready holds low, the next batch end waits for the
// register to drain before its result is written.
// Reset (rst, synchronous) clears configuration, sums, count, byte phase, state and m_tvalid.
module touch_sample_average_calibrate #(
  parameter int MAX_SAMPLES = tsac_pkg::MAX_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tsac_pkg::DATA_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                             s_tlast,   // batch_end
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tsac_pkg::OUT_W-1:0]       m_tdata,   // [15:0] pos_x, [31:16] pos_y,
                                                      // [39:32] pressure,
                                                      // [47:40] samples_used
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tsac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Sample count and sum widths follow from the sample limit
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SXW = 12 + CW;
  localparam int SZW = 8 + CW;
  localparam int NW  = 34;                 // dividend width
  localparam int DW  = 32;                 // divisor width
  localparam int IW  = $clog2(NW);

  localparam logic [3:0] NIB = 4'hF;

  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_OFF_X = 3'd1;
  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_RAT_X = 3'd2;
  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_OFF_Y = 3'd3;
  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_RAT_Y = 3'd4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [2:0] OP_AX = 3'd0;
  localparam logic [2:0] OP_AY = 3'd1;
  localparam logic [2:0] OP_AZ = 3'd2;
  localparam logic [2:0] OP_CX = 3'd3;
  localparam logic [2:0] OP_CY = 3'd4;

  localparam logic [1:0] PH_B0 = 2'd0;
  localparam logic [1:0] PH_B1 = 2'd1;
  localparam logic [1:0] PH_B2 = 2'd2;
  localparam logic [1:0] PH_B3 = 2'd3;

  // Configuration
  logic               xyz_mode;
  logic signed [31:0] bias_x, ratio_x, bias_y, ratio_y;

  // Batch accumulation
  logic [1:0]     phase, phase_next;
  logic [23:0]    ps, ps_next;
  logic [SXW-1:0] sum_x, sum_y;
  logic [SZW-1:0] sum_z;
  logic [CW-1:0]  count;
  logic           add_en;
  logic [7:0]     z_add;
  logic           in_acc;

  // Sequencer and shared divider
  logic [2:0]     state, op;
  logic [IW-1:0]  iter;
  logic [DW-1:0]  rem, dvs;
  logic [NW-1:0]  quo;
  logic           neg;
  logic [DW:0]    shifted;
  logic [DW+1:0]  trial;
  logic           ge;

  // Operand setup
  logic [NW-1:0]  ld_num;
  logic [DW-1:0]  ld_dvs;
  logic           ld_neg;
  logic signed [NW-1:0] cal_num;
  logic [11:0]    cal_avg;
  logic signed [31:0] cal_off, cal_rat;

  // Results
  logic [11:0]    avg_x, avg_y;
  logic [7:0]     avg_z;
  logic [15:0]    res_x, res_y;
  logic [15:0]    cal_res;
  logic           out_free;

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Byte packing: x = {b0, b1[7:4]}, y = {b1[3:0], b2}
  always_comb begin
    phase_next = PH_B0;
    ps_next    = ps;
    add_en     = 1'b0;
    z_add      = 8'd0;
    unique case (phase)
      PH_B0: begin
        ps_next    = {s_tdata, 16'h0000};
        phase_next = PH_B1;
      end
      PH_B1: begin
        ps_next    = {ps[23:16], s_tdata[7:4], s_tdata[3:0] & NIB, 8'h00};
        phase_next = PH_B2;
      end
      PH_B2: begin
        ps_next = {ps[23:8], s_tdata};
        if (xyz_mode) begin
          add_en     = 1'b1;
          z_add      = 8'd1;
          phase_next = PH_B0;
        end else begin
          phase_next = PH_B3;
        end
      end
      PH_B3: begin
        // Three-byte mode drops a stray fourth byte
        add_en     = !xyz_mode;
        z_add      = s_tdata;
        phase_next = PH_B0;
      end
      default: phase_next = PH_B0;
    endcase
    // Hold the sums once the sample limit is reached
    if (count >= CW'(MAX_SAMPLES)) begin
      add_en = 1'b0;
    end
  end

  // Divider operands for the current operation
  always_comb begin
    cal_avg = (op == OP_CY) ? avg_y : avg_x;
    cal_off = (op == OP_CY) ? bias_y : bias_x;
    cal_rat = (op == OP_CY) ? ratio_y : ratio_x;
    cal_num = $signed({6'd0, cal_avg, 16'h0000}) - $signed({{2{cal_off[31]}}, cal_off});
    ld_num  = NW'(sum_x);
    ld_dvs  = DW'(count);
    ld_neg  = 1'b0;
    unique case (op) inside
      OP_AX: ld_num = NW'(sum_x);
      OP_AY: ld_num = NW'(sum_y);
      OP_AZ: ld_num = NW'(sum_z);
      OP_CX, OP_CY: begin
        ld_num = cal_num[NW-1] ? NW'(-cal_num) : NW'(cal_num);
        ld_dvs = cal_rat[31] ? DW'(-cal_rat) : DW'(cal_rat);
        ld_neg = cal_num[NW-1] ^ cal_rat[31];
      end
      default: ld_num = NW'(sum_x);
    endcase
  end

  // One restoring step: shift in a dividend bit, subtract if it fits
  assign shifted = {rem, quo[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};
  assign ge      = !trial[DW+1];

  // Saturate the signed quotient, or pass the raw average when ratio is zero
  always_comb begin
    if (cal_rat == 32'sd0) begin
      cal_res = {4'h0, cal_avg};
    end else if (!neg) begin
      cal_res = (quo > NW'(32767)) ? 16'h7FFF : quo[15:0];
    end else begin
      cal_res = (quo > NW'(32768)) ? 16'h8000 : 16'(-quo[15:0]);
    end
  end

  // Control: configuration, accumulation, sequencer, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      xyz_mode <= 1'b0;
      bias_x   <= '0;
      ratio_x  <= '0;
      bias_y   <= '0;
      ratio_y  <= '0;
      phase    <= PH_B0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_z    <= '0;
      count    <= '0;
      state    <= S_IDLE;
      op       <= OP_AX;
      iter     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE:  xyz_mode <= cfg_data[0];
          REG_OFF_X: bias_x   <= cfg_data;
          REG_RAT_X: ratio_x  <= cfg_data;
          REG_OFF_Y: bias_y   <= cfg_data;
          REG_RAT_Y: ratio_y  <= cfg_data;
          default: ;
        endcase
      end
      // Raise valid as a result is loaded, drop it once the beat is taken
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            phase <= phase_next;
            if (add_en) begin
              sum_x <= sum_x + SXW'(ps_next[23:12]);
              sum_y <= sum_y + SXW'(ps_next[11:0]);
              sum_z <= sum_z + SZW'(z_add);
              count <= count + 1'b1;
            end
            if (s_tlast) begin
              op    <= OP_AX;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          iter  <= IW'(NW - 1);
          state <= S_RUN;
        end
        S_RUN: begin
          if (iter == '0) begin
            state <= S_STORE;
          end else begin
            iter <= iter - 1'b1;
          end
        end
        S_STORE: begin
          unique case (op)
            OP_AX:   begin op <= OP_AY; state <= S_LOAD; end
            OP_AY:   begin op <= OP_AZ; state <= S_LOAD; end
            OP_AZ:   begin op <= OP_CX; state <= S_LOAD; end
            OP_CX:   begin op <= OP_CY; state <= S_LOAD; end
            default: state <= S_OUT;
          endcase
        end
        S_OUT: begin
          // Wait for the output register, then start a fresh batch
          if (out_free) begin
            phase    <= PH_B0;
            sum_x    <= '0;
            sum_y    <= '0;
            sum_z    <= '0;
            count    <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: packing register, divider, results, output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ps <= ps_next;
    end
    unique case (state)
      S_LOAD: begin
        rem <= '0;
        quo <= ld_num;
        dvs <= ld_dvs;
        neg <= ld_neg;
      end
      S_RUN: begin
        rem <= ge ? trial[DW-1:0] : shifted[DW-1:0];
        quo <= {quo[NW-2:0], ge};
      end
      S_STORE: begin
        unique case (op)
          OP_AX:   avg_x <= (count == '0) ? 12'd0 : quo[11:0];
          OP_AY:   avg_y <= (count == '0) ? 12'd0 : quo[11:0];
          OP_AZ:   avg_z <= (count == '0) ? 8'd0 : quo[7:0];
          OP_CX:   res_x <= cal_res;
          default: res_y <= cal_res;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= {8'(count), avg_z, res_y, res_x};
        end
      end
      default: ;
    endcase
  end

endmodule

[src/tsac_checker.sv]
`include "touch_sample_average_calibrate_macros.svh"

module tsac_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [tsac_pkg::OUT_W-1:0]  m_tdata
);

  // A stalled result beat holds its payload
  `TSAC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed under stall")

  // The batch end starts the divide sequence, so input closes
  `TSAC_ASSERT_NEXT(a_busy_after_end, s_tvalid && s_tready && s_tlast, !s_tready, "input open right after batch end")

  // No result beat rises straight from the idle state with no result pending
  `TSAC_ASSERT_NEXT(a_no_spurious, !m_tvalid && s_tready, !m_tvalid, "result beat without a batch end")

  // Reset leaves no result pending and the input open
  `TSAC_ASSERT_RST(a_reset_state, !m_tvalid && s_tready, "bad state after reset")

endmodule

bind touch_sample_average_calibrate tsac_checker u_tsac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/touch_average_tb_pkg.sv]
package touch_average_tb_pkg;

  // Register map of the calibration port
  typedef enum logic [tsac_pkg::CFG_IDX_W-1:0] {
    REG_XYZ_MODE = 3'd0,
    REG_BIAS_X   = 3'd1,
    REG_RATIO_X  = 3'd2,
    REG_BIAS_Y   = 3'd3,
    REG_RATIO_Y  = 3'd4
  } cal_reg_e;

  // xyz_mode values
  localparam logic FOUR_BYTE_SAMPLES  = 1'b0;
  localparam logic THREE_BYTE_SAMPLES = 1'b1;

endpackage

[tb/touch_sample_average_calibrate_checker.sv]
module touch_sample_average_calibrate_checker
  import touch_average_tb_pkg::*;
#(
  parameter int MAX_SAMPLES = tsac_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tsac_pkg::DATA_W-1:0]     s_tdata,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [tsac_pkg::OUT_W-1:0]      m_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsac_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              reports_seen,
  output int                              capped_batches
);

  typedef struct packed {
    logic [7:0]         samples_used;
    logic [7:0]         pressure;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } touch_report_t;

  logic               sample_mode;
  logic signed [31:0] cal_bias_x;
  logic signed [31:0] cal_ratio_x;
  logic signed [31:0] cal_bias_y;
  logic signed [31:0] cal_ratio_y;

  logic [1:0]  byte_phase;
  logic [23:0] partial;
  logic [18:0] sum_x;
  logic [18:0] sum_y;
  logic [14:0] sum_z;
  logic [7:0]  sample_count;
  bit          cap_hit;

  touch_report_t expected_reports[$];

  task automatic flag_mismatch(input string msg);
    $display("%0t check: %s", $time, msg);
    mismatches++;
  endtask

  // ((avg << 16) - offset) / ratio, truncated toward zero, then clamped; avg when ratio is 0
  function automatic logic signed [15:0] calibrated_axis(input logic [11:0] avg,
                                                         input logic signed [31:0] offset,
                                                         input logic signed [31:0] ratio);
    longint avg_l;
    longint off_l;
    longint ratio_l;
    longint q;
    avg_l   = avg;
    off_l   = offset;
    ratio_l = ratio;
    if (ratio == 0)
      q = avg_l;
    else
      q = (avg_l * 65536 - off_l) / ratio_l;
    if (q > 32767)
      q = 32767;
    if (q < -32768)
      q = -32768;
    return q[15:0];
  endfunction

  task automatic clear_batch();
    byte_phase   = 2'd0;
    partial      = '0;
    sum_x        = '0;
    sum_y        = '0;
    sum_z        = '0;
    sample_count = '0;
    cap_hit      = 1'b0;
  endtask

  task automatic accumulate(input logic [7:0] z);
    if (sample_count >= MAX_SAMPLES) begin
      cap_hit = 1'b1;
    end else begin
      sum_x = sum_x + partial[23:12];
      sum_y = sum_y + partial[11:0];
      sum_z = sum_z + z;
      sample_count++;
    end
  endtask

  task automatic take_byte(input logic [7:0] b, input logic batch_end);
    touch_report_t r;
    logic [18:0]   avg_x;
    logic [18:0]   avg_y;
    logic [14:0]   avg_z;
    case (byte_phase)
      2'd0: begin
        partial    = {b, 16'h0000};
        byte_phase = 2'd1;
      end
      2'd1: begin
        partial    = {partial[23:16], b, 8'h00};
        byte_phase = 2'd2;
      end
      2'd2: begin
        partial[7:0] = b;
        if (sample_mode == THREE_BYTE_SAMPLES) begin
          accumulate(8'd1);
          byte_phase = 2'd0;
        end else begin
          byte_phase = 2'd3;
        end
      end
      default: begin
        if (sample_mode == FOUR_BYTE_SAMPLES)
          accumulate(b);
        byte_phase = 2'd0;
      end
    endcase
    if (batch_end) begin
      if (sample_count != 0) begin
        avg_x = sum_x / sample_count;
        avg_y = sum_y / sample_count;
        avg_z = sum_z / sample_count;
      end else begin
        avg_x = '0;
        avg_y = '0;
        avg_z = '0;
      end
      r.pos_x        = calibrated_axis(avg_x[11:0], cal_bias_x, cal_ratio_x);
      r.pos_y        = calibrated_axis(avg_y[11:0], cal_bias_y, cal_ratio_y);
      r.pressure     = avg_z[7:0];
      r.samples_used = sample_count;
      expected_reports.push_back(r);
      if (cap_hit)
        capped_batches++;
      clear_batch();
    end
  endtask

  task automatic check_report(input touch_report_t got);
    touch_report_t want;
    reports_seen++;
    if (expected_reports.size() == 0) begin
      flag_mismatch($sformatf("result beat %h with no batch end pending", got));
    end else begin
      want = expected_reports.pop_front();
      if (got.pos_x !== want.pos_x)
        flag_mismatch($sformatf("pos_x got %0d expected %0d", got.pos_x, want.pos_x));
      if (got.pos_y !== want.pos_y)
        flag_mismatch($sformatf("pos_y got %0d expected %0d", got.pos_y, want.pos_y));
      if (got.pressure !== want.pressure)
        flag_mismatch($sformatf("pressure got %0d expected %0d", got.pressure,
                                want.pressure));
      if (got.samples_used !== want.samples_used)
        flag_mismatch($sformatf("samples_used got %0d expected %0d", got.samples_used,
                                want.samples_used));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_mode    = FOUR_BYTE_SAMPLES;
      cal_bias_x     = '0;
      cal_ratio_x    = '0;
      cal_bias_y     = '0;
      cal_ratio_y    = '0;
      clear_batch();
      expected_reports.delete();
      mismatches     = 0;
      pending        = 0;
      reports_seen   = 0;
      capped_batches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_XYZ_MODE: sample_mode = cfg_data[0];
          REG_BIAS_X:   cal_bias_x  = cfg_data;
          REG_RATIO_X:  cal_ratio_x = cfg_data;
          REG_BIAS_Y:   cal_bias_y  = cfg_data;
          REG_RATIO_Y:  cal_ratio_y = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready)
        check_report(m_tdata);
      if (s_tvalid && s_tready)
        take_byte(s_tdata, s_tlast);
      pending = expected_reports.size();
    end
  end

endmodule

[tb/touch_sample_average_calibrate_tb.sv]
module touch_sample_average_calibrate_tb;
  import touch_average_tb_pkg::*;

  // Longest quiet stretch is a batch end in the divider plus an
  // output stall, a settle pause and a source gap; the drain at the end is
  // DRAIN_CYCLES. Allow several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 200;
  localparam int TOTAL_BYTES    = 1420;
  localparam int CALM_FROM      = 1220;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [tsac_pkg::DATA_W-1:0]     s_tdata   = '0;   // [7:0] data_byte
  logic                            s_tlast   = 1'b0; // batch_end
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [tsac_pkg::OUT_W-1:0]      m_tdata;          // [15:0] pos_x, [31:16] pos_y,
                                                     // [39:32] pressure,
                                                     // [47:40] samples_used
  logic                            cfg_valid = 1'b0;
  logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tsac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            cfg_ready;

  int mismatches;
  int pending;
  int reports_seen;
  int capped_batches;

  int  bytes_sent  = 0;
  int  settings    = 0;
  int  idle_cycles = 0;
  int  sink_stall  = 0;
  bit  calm        = 1'b0;
  logic cur_mode   = FOUR_BYTE_SAMPLES;

  touch_sample_average_calibrate DUT (.*);

  touch_sample_average_calibrate_checker u_check (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Result sink: drop tready in random bursts of random length, hold it high
  // once the run has gone calm.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 7);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte, entered and left at a falling edge. Valid stays high on
  // return so back-to-back bytes run without a bubble; whoever does something
  // else next must lower it.
  task automatic send_byte(input logic [7:0] b, input logic batch_end);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap      = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= batch_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    // The tail of the run goes without idling on either side
    if (bytes_sent >= CALM_FROM)
      calm = 1'b1;
  endtask

  // Quiesce the stream: wait for every pending result, then give the block
  // time to finish any byte still in flight before a register write.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cal_reg_e idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_XYZ_MODE)
      cur_mode = value[0];
  endtask

  // Whole samples of random content, then an optional partial tail; the last
  // byte carries the batch end. Zero samples and no tail still sends one byte.
  task automatic send_batch(input int samples, input int tail);
    int per_sample;
    int total;
    per_sample = (cur_mode == THREE_BYTE_SAMPLES) ? 3 : 4;
    total      = samples * per_sample + tail;
    if (total == 0)
      total = 1;
    for (int i = 0; i < total; i++)
      send_byte($urandom_range(0, 255), i == total - 1);
  endtask

  // Mix of the extremes, full random words and values in a useful range
  // (ratio near 1.0 in 16.16, offsets within the span of avg << 16).
  function automatic logic [31:0] random_cal_word(input bit is_ratio);
    logic [31:0] mag;
    case ($urandom_range(0, 11)) inside
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return 32'h0000_0000;
      4:       return is_ratio ? 32'h0000_0001 : 32'hFFFF_FFFF;
      5:       return is_ratio ? 32'hFFFF_FFFF : 32'h0000_0001;
      6:       return $urandom();
      default: begin
        mag = is_ratio ? $urandom_range(32'h0000_1000, 32'h0004_0000)
                       : $urandom_range(32'h0000_0000, 32'h1000_0000);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  initial begin
    int phase_no;
    int n_batches;
    int kind;
    int per_sample;
    int n_noise;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings: four-byte samples, raw pass-through.
    // Lone flagged byte: no complete sample, all averages zero.
    send_byte(8'h5A, 1'b1);
    // All ones: x = y = 4095, pressure 255.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // All zeros, then a flagged byte that starts a sample and is dropped.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // Two samples averaged.
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h01, 1'b1);

    // Extreme calibration words on both axes.
    settle();
    write_reg(REG_BIAS_X,  32'h8000_0000);
    write_reg(REG_RATIO_X, 32'h7FFF_FFFF);
    write_reg(REG_BIAS_Y,  32'h7FFF_FFFF);
    write_reg(REG_RATIO_Y, 32'h8000_0000);
    settings++;

    // Mode change mid-sample: three bytes in four-byte mode leave the phase at
    // its last step; after the switch the next byte is discarded.
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    settle();
    write_reg(REG_XYZ_MODE, {31'd0, THREE_BYTE_SAMPLES});
    send_byte(8'h3C, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h7F, 1'b1);

    // Random phases: fresh settings each time, then a handful of batches.
    phase_no = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      settle();
      write_reg(REG_XYZ_MODE, {31'd0, 1'($urandom_range(0, 1))});
      write_reg(REG_BIAS_X,   random_cal_word(1'b0));
      write_reg(REG_RATIO_X,  random_cal_word(1'b1));
      write_reg(REG_BIAS_Y,   random_cal_word(1'b0));
      write_reg(REG_RATIO_Y,  random_cal_word(1'b1));
      settings++;
      per_sample = (cur_mode == THREE_BYTE_SAMPLES) ? 3 : 4;
      n_batches  = $urandom_range(4, 10);
      for (int b = 0; b < n_batches; b++) begin
        kind = $urandom_range(0, 19);
        if (phase_no == 2 && b == 0) begin
          // Overrun the sample cap once.
          send_batch(tsac_pkg::MAX_SAMPLES_DEF + 2, 0);
        end else if (kind < 15) begin
          send_batch(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8), 0);
        end else if (kind < 18) begin
          send_batch($urandom_range(0, 6), $urandom_range(1, per_sample - 1));
        end else begin
          // Noise: batch ends at random spots.
          n_noise = $urandom_range(1, 10);
          for (int i = 0; i < n_noise; i++)
            send_byte($urandom_range(0, 255),
                      (i == n_noise - 1) || ($urandom_range(0, 3) == 0));
        end
      end
      // Leave a sample open now and then so the next mode write lands mid-sample.
      if ($urandom_range(0, 2) == 0) begin
        n_noise = $urandom_range(1, 3);
        for (int i = 0; i < n_noise; i++)
          send_byte($urandom_range(0, 255), 1'b0);
      end
      phase_no++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run: %0d bytes over %0d register settings in both sample formats,",
             bytes_sent, settings);
    $display("     %0d batch results compared, %0d batches overran the sample cap",
             reports_seen, capped_batches);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
